/* design/iiel_pkg.sv */
// Shared types, codes and field widths for the indexed insert/erase list.
package iiel_pkg;

  localparam int ACTION_W        = 3;
  localparam int IDX_W           = 4;
  localparam int VALUE_W         = 32;
  localparam int STATUS_W        = 2;
  localparam int COUNT_W         = 5;
  localparam int LIST_CAPACITY   = 16;
  localparam int LIST_DATA_WIDTH = 32;

  typedef enum logic [ACTION_W-1:0] {
    ACT_READ   = 3'd0,
    ACT_APPEND = 3'd1,
    ACT_POP    = 3'd2,
    ACT_INSERT = 3'd3,
    ACT_ERASE  = 3'd4,
    ACT_CLEAR  = 3'd5
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  // Datapath to controller: flags of the held item against the list.
  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic                empty;
    logic                full;
    logic                idx_lt_cnt;
    logic                idx_gt_cnt;
  } dp_stat_t;

  // Controller to datapath: load, execute and update strobes, and the result status.
  typedef struct packed {
    logic    load;
    logic    exec;
    logic    wr_append;
    logic    wr_insert;
    logic    wr_erase;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    cnt_clr;
    logic    rd_en;
    status_t result;
  } dp_cmd_t;

endpackage

/* design/iiel_ctrl.sv */
// Controller: load/execute sequencing, output valid and per-action decode.
module iiel_ctrl import iiel_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t  state;
  logic    go;
  logic    wr_append;
  logic    wr_insert;
  logic    wr_erase;
  logic    cnt_inc;
  logic    cnt_dec;
  logic    cnt_clr;
  logic    rd_en;
  status_t result;

  assign in_stall = (state == S_EXEC);
  // Execute once the output register is free or being drained this cycle.
  assign go = (state == S_EXEC) && (!out_valid || !out_stall);

  always_comb begin
    wr_append = 1'b0;
    wr_insert = 1'b0;
    wr_erase  = 1'b0;
    cnt_inc   = 1'b0;
    cnt_dec   = 1'b0;
    cnt_clr   = 1'b0;
    rd_en     = 1'b0;
    result    = STAT_OK;
    unique case (stat.action)
      ACT_READ: begin
        if (stat.idx_lt_cnt) rd_en = 1'b1;
        else result = STAT_RANGE;
      end
      ACT_APPEND: begin
        if (stat.full) begin
          result = STAT_FULL;
        end else begin
          wr_append = 1'b1;
          cnt_inc   = 1'b1;
        end
      end
      ACT_POP: begin
        if (stat.empty) result = STAT_RANGE;
        else cnt_dec = 1'b1;
      end
      ACT_INSERT: begin
        priority if (stat.idx_gt_cnt) begin
          result = STAT_RANGE;
        end else if (stat.full) begin
          result = STAT_FULL;
        end else begin
          wr_insert = 1'b1;
          cnt_inc   = 1'b1;
        end
      end
      ACT_ERASE: begin
        if (!stat.idx_lt_cnt) begin
          result = STAT_RANGE;
        end else begin
          wr_erase = 1'b1;
          cnt_dec  = 1'b1;
        end
      end
      ACT_CLEAR: cnt_clr = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    cmd.load      = in_valid && !in_stall;
    cmd.exec      = go;
    cmd.wr_append = go && wr_append;
    cmd.wr_insert = go && wr_insert;
    cmd.wr_erase  = go && wr_erase;
    cmd.cnt_inc   = go && cnt_inc;
    cmd.cnt_dec   = go && cnt_dec;
    cmd.cnt_clr   = go && cnt_clr;
    cmd.rd_en     = rd_en;
    cmd.result    = result;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) state <= S_EXEC;
        S_EXEC: if (go) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
      if (go) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

endmodule

/* design/iiel_dpath.sv */
// Datapath: item register, row of list cells, count and result register.
module iiel_dpath import iiel_pkg::*; #(
  parameter int CAPACITY   = LIST_CAPACITY,
  parameter int DATA_WIDTH = LIST_DATA_WIDTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [ACTION_W-1:0] action,
  input  logic [IDX_W-1:0]    index,
  input  logic [VALUE_W-1:0]  value,
  input  dp_cmd_t             cmd,
  output dp_stat_t            stat,
  output logic [VALUE_W-1:0]  read_value,
  output logic [STATUS_W-1:0] status,
  output logic [COUNT_W-1:0]  count
);

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int AW   = $clog2(CAPACITY);
  localparam int CMPW = (CW > IDX_W) ? CW : IDX_W;

  logic [ACTION_W-1:0]   act_q;
  logic [IDX_W-1:0]      idx_q;
  logic [DATA_WIDTH-1:0] val_q;
  logic [CW-1:0]         cnt;
  logic [CW-1:0]         cnt_next;
  logic [DATA_WIDTH-1:0] entries      [CAPACITY];
  logic [DATA_WIDTH-1:0] entries_next [CAPACITY];
  logic [CMPW-1:0]       idx_w;
  logic [CMPW-1:0]       cnt_w;
  logic [AW-1:0]         rd_addr;

  assign idx_w   = CMPW'(idx_q);
  assign cnt_w   = CMPW'(cnt);
  assign rd_addr = AW'(idx_q);

  always_comb begin
    stat.action     = act_q;
    stat.empty      = (cnt == '0);
    stat.full       = (cnt == CW'(CAPACITY));
    stat.idx_lt_cnt = (idx_w < cnt_w);
    stat.idx_gt_cnt = (idx_w > cnt_w);
  end

  // Every cell picks its own next word: hold, take the new word, or take a neighbor.
  always_comb begin
    logic [CMPW-1:0] pos;
    logic [CMPW-1:0] pos_up;
    for (int i = 0; i < CAPACITY; i++) begin
      pos    = CMPW'(i);
      pos_up = CMPW'(i + 1);
      entries_next[i] = entries[i];
      if (cmd.wr_append && (pos == cnt_w)) begin
        entries_next[i] = val_q;
      end
      if (cmd.wr_insert) begin
        if (pos == idx_w) entries_next[i] = val_q;
        else if ((pos > idx_w) && (pos <= cnt_w)) entries_next[i] = entries[(i > 0) ? i - 1 : 0];
      end
      if (cmd.wr_erase && (pos >= idx_w) && (pos_up < cnt_w)) begin
        entries_next[i] = entries[(i + 1 < CAPACITY) ? i + 1 : i];
      end
    end
  end

  always_comb begin
    priority if (cmd.cnt_clr) cnt_next = '0;
    else if (cmd.cnt_inc) cnt_next = cnt + 1'b1;
    else if (cmd.cnt_dec) cnt_next = cnt - 1'b1;
    else cnt_next = cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    entries <= entries_next;
    if (cmd.load) begin
      act_q <= action;
      idx_q <= index;
      val_q <= DATA_WIDTH'(value);
    end
    if (cmd.exec) begin
      read_value <= cmd.rd_en ? VALUE_W'(entries[rd_addr]) : '0;
      status     <= cmd.result;
      count      <= COUNT_W'(cnt_next);
    end
  end

endmodule

/* design/indexed_insert_erase_list.sv */
// Each input beat is loaded into the item register and executed once the result
//   register is free, which registers the result; no new beat is taken before then,
//   and each insert or erase moves all cells in parallel in the execute cycle.
// An input beat is taken while the previous result still waits on out_stall.
// Reset (rst, synchronous, active high) empties the list and drops any result
//   beat; stored words are left undefined and are never read before written.
module indexed_insert_erase_list import iiel_pkg::*; #(
  parameter int CAPACITY   = LIST_CAPACITY,
  parameter int DATA_WIDTH = LIST_DATA_WIDTH
) (
  input  logic                clk,
  input  logic                rst,
  // input channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [ACTION_W-1:0] action,
  input  logic [IDX_W-1:0]    index,
  input  logic [VALUE_W-1:0]  value,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic [VALUE_W-1:0]  read_value,
  output logic [STATUS_W-1:0] status,
  output logic [COUNT_W-1:0]  count
);

  dp_stat_t stat;
  dp_cmd_t  cmd;

  // Sequence each beat: load it, then execute when the result register frees up.
  iiel_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Hold the list cells, the count and the result register.
  iiel_dpath #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .action     (action),
    .index      (index),
    .value      (value),
    .cmd        (cmd),
    .stat       (stat),
    .read_value (read_value),
    .status     (status),
    .count      (count)
  );

`ifndef NO_ASSERTIONS
  // A full status only ever comes with a full list.
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == STAT_FULL)) |-> (count == COUNT_W'(CAPACITY)))
    else $error("full status with list not full");

  // A failed action never returns a word.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != STAT_OK)) |-> (read_value == '0))
    else $error("nonzero read word on failed action");

  // An accepted beat blocks the input for the execute cycle.
  a_accept_stall: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken twice in a row");
`endif

endmodule
